>>> rtl/pe2rgb_pkg.sv
// Shared types, constants and helper functions for the photon energy to RGB block.
// Depends on nothing; the top level and its checker import it.
package pe2rgb_pkg;

  localparam int ENERGY_W      = 16;
  localparam int LEVEL_W       = 8;
  localparam int ENERGY_FRAC_BITS_DEF     = 12;
  localparam int WAVELENGTH_FRAC_BITS_DEF = 4;

  // hc/e in nm*eV, scaled by 2^24 and rounded to nearest.
  localparam int HC_W = 35;
  localparam logic [HC_W-1:0] HC_NM_Q24 = 35'd20801096777;
  localparam int HC_SCALE_BITS = 24;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

  // Segment boundaries in whole nanometres.
  localparam int BAND_LO     = 380;
  localparam int BAND_BLUE   = 440;
  localparam int BAND_CYAN   = 490;
  localparam int BAND_GREEN  = 510;
  localparam int BAND_YELLOW = 580;
  localparam int BAND_RED    = 645;
  localparam int BAND_HI     = 780;

  // Width of each ramp segment in whole nanometres.
  localparam int DIV_W = 7;
  localparam logic [DIV_W-1:0] SPAN_VIOLET = 7'd60;
  localparam logic [DIV_W-1:0] SPAN_BLUE   = 7'd50;
  localparam logic [DIV_W-1:0] SPAN_CYAN   = 7'd20;
  localparam logic [DIV_W-1:0] SPAN_GREEN  = 7'd70;
  localparam logic [DIV_W-1:0] SPAN_YELLOW = 7'd65;

  // Scaled ramp value 255*d/S stays below 255*70, which fits in 15 bits.
  localparam int YW = 15;

  // Reciprocals for the constant divides, floor(2^RECIP_SHIFT / span).
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 16;
  localparam logic [RECIP_W-1:0] RECIP_VIOLET = RECIP_W'((1 << RECIP_SHIFT) / 60);
  localparam logic [RECIP_W-1:0] RECIP_BLUE   = RECIP_W'((1 << RECIP_SHIFT) / 50);
  localparam logic [RECIP_W-1:0] RECIP_CYAN   = RECIP_W'((1 << RECIP_SHIFT) / 20);
  localparam logic [RECIP_W-1:0] RECIP_GREEN  = RECIP_W'((1 << RECIP_SHIFT) / 70);
  localparam logic [RECIP_W-1:0] RECIP_YELLOW = RECIP_W'((1 << RECIP_SHIFT) / 65);

  typedef enum logic [2:0] {
    SEG_BLACK,
    SEG_VIOLET,
    SEG_BLUE,
    SEG_CYAN,
    SEG_GREEN,
    SEG_YELLOW,
    SEG_RED
  } seg_t;

  function automatic logic [DIV_W-1:0] seg_divisor(input seg_t seg);
    logic [DIV_W-1:0] c;
    unique case (seg)
      SEG_VIOLET: c = SPAN_VIOLET;
      SEG_BLUE:   c = SPAN_BLUE;
      SEG_CYAN:   c = SPAN_CYAN;
      SEG_GREEN:  c = SPAN_GREEN;
      SEG_YELLOW: c = SPAN_YELLOW;
      default:    c = DIV_W'(1);
    endcase
    return c;
  endfunction

  function automatic logic [RECIP_W-1:0] seg_recip(input seg_t seg);
    logic [RECIP_W-1:0] m;
    unique case (seg)
      SEG_VIOLET: m = RECIP_VIOLET;
      SEG_BLUE:   m = RECIP_BLUE;
      SEG_CYAN:   m = RECIP_CYAN;
      SEG_GREEN:  m = RECIP_GREEN;
      SEG_YELLOW: m = RECIP_YELLOW;
      default:    m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/photon_energy_to_rgb.sv
// Photon energy to RGB color: pipelined constant-over-energy divider and spectrum ramp.
// Depends on pe2rgb_pkg for constants, the segment type and reciprocal tables.
// The divider has ND = ceil(quotient bits / 4) stages, then five mapping stages follow;
// at the default parameters there are 27 quotient bits, four per divider stage.
// Throughput is one beat per cycle while m_tready holds; each stage loads when it is empty or moves on.
// Synchronous reset clears only the valid bits; payload registers are not reset.
module photon_energy_to_rgb #(
  parameter int ENERGY_FRAC_BITS     = pe2rgb_pkg::ENERGY_FRAC_BITS_DEF,
  parameter int WAVELENGTH_FRAC_BITS = pe2rgb_pkg::WAVELENGTH_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pe2rgb_pkg::ENERGY_W-1:0]  s_tdata,   // [15:0] energy_fixed
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [3*pe2rgb_pkg::LEVEL_W-1:0] m_tdata    // blue_level, green_level, red_level (red in the low byte)
);
  import pe2rgb_pkg::*;

  // Dividend: floor(HC_NM_Q24 * 2^(EF+WF) / 2^24), so that L = floor(K / energy).
  localparam logic [HC_W-1:0] K = HC_NM_Q24 >>
                                  (HC_SCALE_BITS - ENERGY_FRAC_BITS - WAVELENGTH_FRAC_BITS);
  localparam int QW  = $clog2(K + 1);
  localparam int BPS = 4;
  localparam int ND  = (QW + BPS - 1) / BPS;
  localparam int QP  = ND * BPS;
  localparam logic [QP-1:0] KP = QP'(K);
  localparam int RW  = ENERGY_W;

  localparam int S  = 1 << WAVELENGTH_FRAC_BITS;
  localparam int DW = $clog2(70 * S + 1);
  localparam int PW = YW + RECIP_W;
  localparam int QCW = LEVEL_W + DIV_W;

  localparam logic [QP-1:0] L_LO     = QP'(BAND_LO * S);
  localparam logic [QP-1:0] L_BLUE   = QP'(BAND_BLUE * S);
  localparam logic [QP-1:0] L_CYAN   = QP'(BAND_CYAN * S);
  localparam logic [QP-1:0] L_GREEN  = QP'(BAND_GREEN * S);
  localparam logic [QP-1:0] L_YELLOW = QP'(BAND_YELLOW * S);
  localparam logic [QP-1:0] L_RED    = QP'(BAND_RED * S);
  localparam logic [QP-1:0] L_HI     = QP'(BAND_HI * S);

  // Divider stages.
  logic [ND-1:0]   dv_vld;
  logic [ND-1:0]   dv_rdy;
  logic [ND-1:0]   dv_load;
  logic [RW-1:0]   dv_rem      [ND];
  logic [QP-1:0]   dv_quo      [ND];
  logic [RW-1:0]   dv_den      [ND];
  logic [RW-1:0]   dv_rem_next [ND];
  logic [QP-1:0]   dv_quo_next [ND];
  logic [RW-1:0]   dv_den_next [ND];

  // Mapping stages.
  logic                a_vld, b_vld, c_vld, e_vld, f_vld;
  logic                a_rdy, b_rdy, c_rdy, e_rdy, f_rdy;
  seg_t                a_seg, b_seg, c_seg, e_seg;
  seg_t                a_seg_next;
  logic [DW-1:0]       a_d, a_d_next;
  logic [YW-1:0]       b_y, b_y_next, c_y, e_y;
  logic [PW-1:0]       c_prod;
  logic [LEVEL_W-1:0]  e_q0, e_q0_next;
  logic [QCW-1:0]      e_q0c, e_q0c_next;
  logic [LEVEL_W-1:0]  f_red, f_green, f_blue;
  logic [LEVEL_W-1:0]  f_red_next, f_green_next, f_blue_next;

  // Ready chain from the output back to the input.
  always_comb begin
    f_rdy = !f_vld || m_tready;
    e_rdy = !e_vld || f_rdy;
    c_rdy = !c_vld || e_rdy;
    b_rdy = !b_vld || c_rdy;
    a_rdy = !a_vld || b_rdy;
    dv_rdy[ND-1] = !dv_vld[ND-1] || a_rdy;
    for (int j = ND - 2; j >= 0; j--) begin
      dv_rdy[j] = !dv_vld[j] || dv_rdy[j+1];
    end
  end

  assign s_tready = dv_rdy[0];

  // Restoring division, BPS quotient bits per stage, MSB first. A zero energy
  // gives an all-ones quotient, which lands beyond the long end and reads black.
  always_comb begin
    logic [RW:0]   trial;
    logic [RW-1:0] r;
    logic [QP-1:0] q;
    logic [RW-1:0] dn;
    for (int j = 0; j < ND; j++) begin
      if (j == 0) begin
        r  = '0;
        q  = '0;
        dn = s_tdata;
        dv_load[j] = dv_rdy[j] && s_tvalid;
      end else begin
        r  = dv_rem[j-1];
        q  = dv_quo[j-1];
        dn = dv_den[j-1];
        dv_load[j] = dv_rdy[j] && dv_vld[j-1];
      end
      for (int b = 0; b < BPS; b++) begin
        trial = {r, KP[QP-1-j*BPS-b]};
        if (trial >= {1'b0, dn}) begin
          r = RW'(trial - {1'b0, dn});
          q = {q[QP-2:0], 1'b1};
        end else begin
          r = trial[RW-1:0];
          q = {q[QP-2:0], 1'b0};
        end
      end
      dv_rem_next[j] = r;
      dv_quo_next[j] = q;
      dv_den_next[j] = dn;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ND; j++) begin
      if (rst) begin
        dv_vld[j] <= 1'b0;
      end else if (dv_rdy[j]) begin
        dv_vld[j] <= (j == 0) ? s_tvalid : dv_vld[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ND; j++) begin
      if (dv_load[j]) begin
        dv_rem[j] <= dv_rem_next[j];
        dv_quo[j] <= dv_quo_next[j];
        dv_den[j] <= dv_den_next[j];
      end
    end
  end

  // Stage A: pick the segment and the distance into its ramp.
  always_comb begin
    logic [QP-1:0] lam;
    lam = dv_quo[ND-1];
    a_d_next = '0;
    priority if (lam < L_LO || lam >= L_HI) begin
      a_seg_next = SEG_BLACK;
    end else if (lam < L_BLUE) begin
      a_seg_next = SEG_VIOLET;
      a_d_next   = DW'(L_BLUE - lam);
    end else if (lam < L_CYAN) begin
      a_seg_next = SEG_BLUE;
      a_d_next   = DW'(lam - L_BLUE);
    end else if (lam < L_GREEN) begin
      a_seg_next = SEG_CYAN;
      a_d_next   = DW'(L_GREEN - lam);
    end else if (lam < L_YELLOW) begin
      a_seg_next = SEG_GREEN;
      a_d_next   = DW'(lam - L_GREEN);
    end else if (lam < L_RED) begin
      a_seg_next = SEG_YELLOW;
      a_d_next   = DW'(L_RED - lam);
    end else begin
      a_seg_next = SEG_RED;
    end
  end

  // Stage B: 255*d, then drop the wavelength fraction bits.
  always_comb begin
    logic [DW+7:0] d255;
    d255     = {a_d, 8'd0} - (DW + 8)'(a_d);
    b_y_next = YW'(d255 >> WAVELENGTH_FRAC_BITS);
  end

  // Stage E: quotient estimate may be one short; stage F corrects it.
  always_comb begin
    e_q0_next  = c_prod[RECIP_SHIFT +: LEVEL_W];
    e_q0c_next = QCW'(e_q0_next * seg_divisor(c_seg));
  end

  always_comb begin
    logic [YW-1:0]      rem;
    logic [LEVEL_W-1:0] lvl;
    rem = e_y - YW'(e_q0c);
    lvl = (rem >= YW'(seg_divisor(e_seg))) ? e_q0 + LEVEL_W'(1) : e_q0;
    f_red_next   = '0;
    f_green_next = '0;
    f_blue_next  = '0;
    unique case (e_seg)
      SEG_VIOLET: begin
        f_red_next  = lvl;
        f_blue_next = LEVEL_MAX;
      end
      SEG_BLUE: begin
        f_green_next = lvl;
        f_blue_next  = LEVEL_MAX;
      end
      SEG_CYAN: begin
        f_green_next = LEVEL_MAX;
        f_blue_next  = lvl;
      end
      SEG_GREEN: begin
        f_red_next   = lvl;
        f_green_next = LEVEL_MAX;
      end
      SEG_YELLOW: begin
        f_red_next   = LEVEL_MAX;
        f_green_next = lvl;
      end
      SEG_RED: begin
        f_red_next = LEVEL_MAX;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
    end else begin
      if (a_rdy) a_vld <= dv_vld[ND-1];
      if (b_rdy) b_vld <= a_vld;
      if (c_rdy) c_vld <= b_vld;
      if (e_rdy) e_vld <= c_vld;
      if (f_rdy) f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && dv_vld[ND-1]) begin
      a_seg <= a_seg_next;
      a_d   <= a_d_next;
    end
    if (b_rdy && a_vld) begin
      b_seg <= a_seg;
      b_y   <= b_y_next;
    end
    if (c_rdy && b_vld) begin
      c_seg  <= b_seg;
      c_y    <= b_y;
      c_prod <= b_y * seg_recip(b_seg);
    end
    if (e_rdy && c_vld) begin
      e_seg <= c_seg;
      e_y   <= c_y;
      e_q0  <= e_q0_next;
      e_q0c <= e_q0c_next;
    end
    if (f_rdy && e_vld) begin
      f_red   <= f_red_next;
      f_green <= f_green_next;
      f_blue  <= f_blue_next;
    end
  end

  assign m_tvalid = f_vld;
  assign m_tdata  = {f_blue, f_green, f_red};

endmodule

>>> rtl/pe2rgb_chk.sv
// Port-level checker for photon_energy_to_rgb, attached by the bind at the end.
// Depends on pe2rgb_pkg for the level width and full-scale level.
module pe2rgb_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [3*pe2rgb_pkg::LEVEL_W-1:0] m_tdata
);
  import pe2rgb_pkg::*;

  logic [LEVEL_W-1:0] red, green, blue;
  assign red   = m_tdata[LEVEL_W-1:0];
  assign green = m_tdata[2*LEVEL_W-1:LEVEL_W];
  assign blue  = m_tdata[3*LEVEL_W-1:2*LEVEL_W];

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Every spectrum color has at least one dark channel.
  a_one_dark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (red == '0 || green == '0 || blue == '0))
    else $error("color with no dark channel");

  // Any color that is not black has one channel at full scale.
  a_one_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata != '0) |->
      (red == LEVEL_MAX || green == LEVEL_MAX || blue == LEVEL_MAX))
    else $error("lit color with no channel at full scale");

  // Reset empties the pipeline: no result and room for input.
  a_rst_out: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result beat shown right after reset");

  a_rst_in: assert property (@(posedge clk) $past(rst) |-> s_tready)
    else $error("input not ready right after reset");

endmodule

bind photon_energy_to_rgb pe2rgb_chk u_pe2rgb_chk (.*);

>>> test/tb_photon_energy_to_rgb.sv
// Self-checking testbench for photon_energy_to_rgb: streams photon energies in and
// compares each RGB beat with a behavioral wavelength and spectrum-ramp predictor.
// Depends on rtl/pe2rgb_pkg.sv and rtl/photon_energy_to_rgb.sv.
`timescale 1ns / 100ps

module tb_photon_energy_to_rgb;
  import pe2rgb_pkg::*;

  localparam int EF = ENERGY_FRAC_BITS_DEF;
  localparam int WF = WAVELENGTH_FRAC_BITS_DEF;
  localparam int RANDOM_PER_PHASE = 442;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 40;

  // Packed so that red sits in the lowest byte, as on m_tdata.
  typedef struct packed {
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] red;
  } rgb_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [ENERGY_W-1:0]    s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [3*LEVEL_W-1:0]   m_tdata;

  logic [ENERGY_W-1:0] energy_q[$];
  rgb_t                color_q[$];
  logic                in_beat;
  int                  tx_idle_pct;
  int                  rx_idle_pct;
  int                  in_count;
  int                  out_count;
  int                  errors;
  int                  hold_left;
  bit                  hold_done;

  photon_energy_to_rgb uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wavelength = hc/E in one division, then the six-segment visible ramp.
  function automatic rgb_t energy_to_rgb(input logic [ENERGY_W-1:0] e);
    longint unsigned num, lam, s;
    rgb_t c;
    c = '0;
    if (e == 0) return c;
    s   = 64'd1 << WF;
    num = 64'(HC_NM_Q24) << (EF + WF);
    lam = (num / 64'(e)) >> HC_SCALE_BITS;
    if (lam < BAND_LO * s || lam >= BAND_HI * s) return c;
    if (lam < BAND_BLUE * s) begin
      c.red  = LEVEL_W'((255 * (BAND_BLUE * s - lam)) / ((BAND_BLUE - BAND_LO) * s));
      c.blue = LEVEL_MAX;
    end else if (lam < BAND_CYAN * s) begin
      c.green = LEVEL_W'((255 * (lam - BAND_BLUE * s)) / ((BAND_CYAN - BAND_BLUE) * s));
      c.blue  = LEVEL_MAX;
    end else if (lam < BAND_GREEN * s) begin
      c.green = LEVEL_MAX;
      c.blue  = LEVEL_W'((255 * (BAND_GREEN * s - lam)) / ((BAND_GREEN - BAND_CYAN) * s));
    end else if (lam < BAND_YELLOW * s) begin
      c.red   = LEVEL_W'((255 * (lam - BAND_GREEN * s)) / ((BAND_YELLOW - BAND_GREEN) * s));
      c.green = LEVEL_MAX;
    end else if (lam < BAND_RED * s) begin
      c.red   = LEVEL_MAX;
      c.green = LEVEL_W'((255 * (BAND_RED * s - lam)) / ((BAND_RED - BAND_YELLOW) * s));
    end else begin
      c.red = LEVEL_MAX;
    end
    return c;
  endfunction

  // Sender: holds a beat until it is taken, otherwise offers the next energy or idles.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_beat) begin
      if (energy_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= energy_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the pipeline up.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_count >= 120) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    rgb_t want, got;
    if (rst) begin
      in_beat <= 1'b0;
    end else begin
      in_beat <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        color_q.push_back(energy_to_rgb(s_tdata));
        in_count++;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        out_count++;
        if (color_q.size() == 0) begin
          $display("%0t: unexpected beat, actual r=%0d g=%0d b=%0d",
                   $time, got.red, got.green, got.blue);
          errors++;
        end else begin
          want = color_q.pop_front();
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            $display("%0t: color mismatch, expected r=%0d g=%0d b=%0d, actual r=%0d g=%0d b=%0d",
                     $time, want.red, want.green, want.blue, got.red, got.green, got.blue);
            errors++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int bands[7];
    longint unsigned num, e_nom;
    int phase;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    in_beat     = 1'b0;
    tx_idle_pct = 37;
    rx_idle_pct = 67;
    in_count    = 0;
    out_count   = 0;
    errors      = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    bands = '{BAND_LO, BAND_BLUE, BAND_CYAN, BAND_GREEN, BAND_YELLOW, BAND_RED, BAND_HI};

    // Zero energy, the huge wavelength of the smallest energy, and the largest energy.
    energy_q.push_back(16'd0);
    energy_q.push_back(16'd1);
    energy_q.push_back(16'hFFFF);
    // Energies just either side of every segment edge, including both ends of the band.
    num = 64'(HC_NM_Q24) << (EF + WF);
    foreach (bands[i]) begin
      e_nom = num / ((64'(bands[i]) << WF) << HC_SCALE_BITS);
      energy_q.push_back(ENERGY_W'(e_nom - 1));
      energy_q.push_back(ENERGY_W'(e_nom));
      energy_q.push_back(ENERGY_W'(e_nom + 1));
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 37; rx_idle_pct = 67; end
        1: begin tx_idle_pct = 67; rx_idle_pct = 37; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      // Mostly visible energies (about 1.5 to 3.5 eV), the rest anywhere in range.
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        case ($urandom_range(9))
          7:       energy_q.push_back(ENERGY_W'($urandom_range(65535)));
          8:       energy_q.push_back(ENERGY_W'($urandom_range(255)));
          9:       energy_q.push_back(ENERGY_W'($urandom()));
          default: energy_q.push_back(ENERGY_W'($urandom_range(14500, 6000)));
        endcase
      end
      while (energy_q.size() != 0) @(posedge clk);
    end

    while (s_tvalid) @(posedge clk);
    while (color_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d photon energies and checked %0d colors over three pacing phases,",
             in_count, out_count);
    $display("covering black, all six spectrum segments, edge energies and a long output stall.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> photon_energy_to_rgb.f
rtl/pe2rgb_pkg.sv
rtl/photon_energy_to_rgb.sv
rtl/pe2rgb_chk.sv
test/tb_photon_energy_to_rgb.sv
